/* rtl/ddrpd_pkg.sv */
// Shared types and constants of the differential-drive ramped PWM duty block.
`default_nettype none

package ddrpd_pkg;

    // One command beat: a new polar setpoint or a ramp tick.
    typedef struct packed {
        logic               opcode;
        logic signed [15:0] linear_speed;
        logic signed [15:0] angular_speed;
    } cmd_t;

    // One result beat: sign-magnitude duties of both motors.
    typedef struct packed {
        logic [15:0] left_primary_duty;
        logic [15:0] left_secondary_duty;
        logic [15:0] right_primary_duty;
        logic [15:0] right_secondary_duty;
    } duty_t;

    localparam logic OP_SETPOINT = 1'b0;
    localparam logic OP_TICK     = 1'b1;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_ACCEL_STEP       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DUTY_OFFSET      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_SCALE     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_TRACK_MM    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PERCENT_PER_SPEED = 3'd4;

    localparam logic [7:0]  ACCEL_STEP_RST        = 8'd5;
    localparam logic [15:0] DUTY_OFFSET_RST       = 16'd50;
    localparam logic [7:0]  PERIOD_SCALE_RST      = 8'd40;
    localparam logic [10:0] HALF_TRACK_MM_RST     = 11'd100;
    localparam logic [15:0] PERCENT_PER_SPEED_RST = 16'd3277;

    // Mixing divisor (mrad to rad) and the percent limit.
    localparam logic [10:0] MIX_DIVISOR   = 11'd1000;
    localparam logic [16:0] PCT_LIMIT     = 17'd100;
    localparam logic [6:0]  PCT_LIMIT_MAG = 7'd100;

    // Bit-serial step counts of the shift-add and shift-subtract loops.
    localparam int MIX_MUL_STEPS  = 11;
    localparam int DIV_STEPS      = 27;
    localparam int PCT_MUL_STEPS  = 16;
    localparam int DUTY_MUL_STEPS = 7;
    localparam int CNT_W          = $clog2(DIV_STEPS);

    localparam logic [CNT_W-1:0] MIX_MUL_LAST  = CNT_W'(MIX_MUL_STEPS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST      = CNT_W'(DIV_STEPS - 1);
    localparam logic [CNT_W-1:0] PCT_MUL_LAST  = CNT_W'(PCT_MUL_STEPS - 1);
    localparam logic [CNT_W-1:0] DUTY_MUL_LAST = CNT_W'(DUTY_MUL_STEPS - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIX_MUL,
        ST_MIX_DIV,
        ST_SUM,
        ST_PCT_MUL,
        ST_CLAMP,
        ST_RAMP,
        ST_DUTY_MUL,
        ST_DUTY_OUT
    } state_t;

endpackage

`default_nettype wire

/* rtl/diff_drive_ramped_pwm_duty.sv */
// Differential-drive motor block: setpoint mixing, ramped percents and PWM duties.
// A tick beat ramps the percents and then forms the duties; a setpoint beat first mixes,
// divides and scales into new clamped targets. The serial divide by 1000 and the percent
// multiply are the longest steps of the setpoint path. A new command is taken only in idle.
// The result register lets a new command enter while the last result waits to be taken.
// Reset (rst_n low, asynchronous) restores the register defaults and zeroes all percents.
`default_nettype none

module diff_drive_ramped_pwm_duty (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 cmd_valid,
    output logic                                      cmd_ready,
    input  wire ddrpd_pkg::cmd_t                      cmd,

    output logic                                      duty_valid,
    input  wire logic                                 duty_ready,
    output ddrpd_pkg::duty_t                          duty,

    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [ddrpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [ddrpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Lane 0 carries the left wheel, lane 1 the right wheel.
    localparam int LANE_LEFT  = 0;
    localparam int LANE_RIGHT = 1;

    // Ramp one current percent toward its target by at most the step.
    function automatic logic signed [7:0] ramp_pct(
        input logic signed [7:0] cur,
        input logic signed [7:0] tgt,
        input logic        [7:0] step
    );
        logic signed [9:0] c;
        logic signed [9:0] t;
        logic signed [9:0] up;
        logic signed [9:0] dn;
        logic signed [9:0] r;
        c  = 10'(cur);
        t  = 10'(tgt);
        up = c + $signed({2'b00, step});
        dn = c - $signed({2'b00, step});
        if (c < t) begin
            r = (up < t) ? up : t;
        end
        else if (c > t) begin
            r = (dn > t) ? dn : t;
        end
        else begin
            r = c;
        end
        return r[7:0];
    endfunction

    // Control state.
    ddrpd_pkg::state_t                  state_reg, state_next;
    logic [ddrpd_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [7:0]                  cur_reg [2];
    logic signed [7:0]                  cur_next [2];
    logic signed [7:0]                  tgt_reg [2];
    logic signed [7:0]                  tgt_next [2];
    logic                               duty_valid_reg, duty_valid_next;

    // Configuration registers.
    logic [7:0]                         accel_step_reg;
    logic [15:0]                        duty_offset_reg;
    logic [7:0]                         period_scale_reg;
    logic [10:0]                        half_track_reg;
    logic [15:0]                        pct_scale_reg;

    // Datapath shift registers.
    logic [15:0]                        lin_reg, lin_next;
    logic                               ang_neg_reg, ang_neg_next;
    logic [15:0]                        mcand_reg, mcand_next;
    logic [26:0]                        mix_reg, mix_next;
    logic [9:0]                         rem_reg, rem_next;
    logic [16:0]                        mag_reg [2];
    logic [16:0]                        mag_next [2];
    logic                               neg_reg [2];
    logic                               neg_next [2];
    logic [32:0]                        pprod_reg [2];
    logic [32:0]                        pprod_next [2];
    logic [14:0]                        dprod_reg [2];
    logic [14:0]                        dprod_next [2];
    logic                               dneg_reg [2];
    logic                               dneg_next [2];
    ddrpd_pkg::duty_t                   duty_reg, duty_next;

    // Combinational datapath terms.
    logic [16:0]                        mix_sum;
    logic [10:0]                        div_trial;
    logic                               div_bit;
    logic [17:0]                        mix_tc;
    logic [17:0]                        lin_ext;
    logic [17:0]                        wheel [2];
    logic [17:0]                        pct_sum [2];
    logic [6:0]                         pct_mag [2];
    logic signed [7:0]                  ramped [2];
    logic signed [7:0]                  cur_src [2];
    logic [6:0]                         cur_mag [2];
    logic [8:0]                         duty_sum [2];
    logic [16:0]                        drive [2];
    logic [15:0]                        drive_sat [2];
    logic                               cmd_take;
    logic                               out_free;

    assign cmd_ready  = (state_reg == ddrpd_pkg::ST_IDLE);
    assign cmd_take   = cmd_valid && cmd_ready;
    assign out_free   = !duty_valid_reg || duty_ready;
    assign cfg_ready  = 1'b1;
    assign duty_valid = duty_valid_reg;
    assign duty       = duty_reg;

    // Arithmetic of each serial step. Every term is narrow: one small add or
    // compare per lane per cycle.
    always_comb
    begin
        // Shift-add multiply |ang| * half_track, one multiplier bit per cycle.
        mix_sum   = {1'b0, mix_reg[26:11]} + {1'b0, mcand_reg};
        // Restoring divide by 1000, one quotient bit per cycle.
        div_trial = {rem_reg, mix_reg[26]};
        div_bit   = (div_trial >= ddrpd_pkg::MIX_DIVISOR);
        // Signed mix term and the two wheel speeds, quotient truncated toward zero.
        mix_tc    = ang_neg_reg ? (~{1'b0, mix_reg[16:0]} + 18'd1) : {1'b0, mix_reg[16:0]};
        lin_ext   = {{2{lin_reg[15]}}, lin_reg};
        wheel[LANE_RIGHT] = lin_ext + mix_tc;
        wheel[LANE_LEFT]  = lin_ext - mix_tc;
        for (int i = 0; i < 2; i++) begin
            pct_sum[i] = {1'b0, pprod_reg[i][32:16]} + {1'b0, mag_reg[i]};
            pct_mag[i] = (pprod_reg[i][32:16] > ddrpd_pkg::PCT_LIMIT)
                       ? ddrpd_pkg::PCT_LIMIT_MAG : pprod_reg[i][6+16:16];
            ramped[i]  = ramp_pct(cur_reg[i], tgt_reg[i], accel_step_reg);
            cur_src[i] = (state_reg == ddrpd_pkg::ST_RAMP) ? ramped[i] : cur_reg[i];
            cur_mag[i] = cur_src[i][7] ? 7'(-cur_src[i]) : cur_src[i][6:0];
            duty_sum[i] = {1'b0, dprod_reg[i][14:7]} + {1'b0, period_scale_reg};
            drive[i]    = {2'b00, dprod_reg[i]} + {1'b0, duty_offset_reg};
            drive_sat[i] = drive[i][16] ? 16'hFFFF : drive[i][15:0];
        end
    end

    // Sequencer: next state, step counter and every register's next value.
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        cur_next        = cur_reg;
        tgt_next        = tgt_reg;
        lin_next        = lin_reg;
        ang_neg_next    = ang_neg_reg;
        mcand_next      = mcand_reg;
        mix_next        = mix_reg;
        rem_next        = rem_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        pprod_next      = pprod_reg;
        dprod_next      = dprod_reg;
        dneg_next       = dneg_reg;
        duty_next       = duty_reg;
        duty_valid_next = duty_valid_reg && !duty_ready;

        unique case (state_reg)
            ddrpd_pkg::ST_IDLE:
            begin
                if (cmd_take) begin
                    if (cmd.opcode == ddrpd_pkg::OP_SETPOINT) begin
                        lin_next     = cmd.linear_speed;
                        ang_neg_next = cmd.angular_speed[15];
                        mcand_next   = cmd.angular_speed[15]
                                     ? 16'(-cmd.angular_speed) : cmd.angular_speed;
                        mix_next     = {16'd0, half_track_reg};
                        cnt_next     = ddrpd_pkg::MIX_MUL_LAST;
                        state_next   = ddrpd_pkg::ST_MIX_MUL;
                    end
                    else begin
                        state_next   = ddrpd_pkg::ST_RAMP;
                    end
                end
            end

            ddrpd_pkg::ST_MIX_MUL:
            begin
                mix_next = mix_reg[0] ? {mix_sum, mix_reg[10:1]} : {1'b0, mix_reg[26:1]};
                if (cnt_reg == '0) begin
                    rem_next   = '0;
                    cnt_next   = ddrpd_pkg::DIV_LAST;
                    state_next = ddrpd_pkg::ST_MIX_DIV;
                end
                else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end

            ddrpd_pkg::ST_MIX_DIV:
            begin
                rem_next = div_bit ? 10'(div_trial - ddrpd_pkg::MIX_DIVISOR) : div_trial[9:0];
                mix_next = {mix_reg[25:0], div_bit};
                if (cnt_reg == '0) begin
                    state_next = ddrpd_pkg::ST_SUM;
                end
                else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end

            ddrpd_pkg::ST_SUM:
            begin
                for (int i = 0; i < 2; i++) begin
                    neg_next[i]   = wheel[i][17];
                    mag_next[i]   = wheel[i][17] ? 17'(~wheel[i] + 18'd1) : wheel[i][16:0];
                    pprod_next[i] = {17'd0, pct_scale_reg};
                end
                cnt_next   = ddrpd_pkg::PCT_MUL_LAST;
                state_next = ddrpd_pkg::ST_PCT_MUL;
            end

            ddrpd_pkg::ST_PCT_MUL:
            begin
                for (int i = 0; i < 2; i++) begin
                    pprod_next[i] = pprod_reg[i][0] ? {pct_sum[i], pprod_reg[i][15:1]}
                                                   : {1'b0, pprod_reg[i][32:1]};
                end
                if (cnt_reg == '0) begin
                    state_next = ddrpd_pkg::ST_CLAMP;
                end
                else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end

            ddrpd_pkg::ST_CLAMP:
            begin
                // The right target takes the opposite sign of its wheel speed.
                tgt_next[LANE_LEFT]  = neg_reg[LANE_LEFT]
                                     ? -$signed({1'b0, pct_mag[LANE_LEFT]})
                                     :  $signed({1'b0, pct_mag[LANE_LEFT]});
                tgt_next[LANE_RIGHT] = neg_reg[LANE_RIGHT]
                                     ?  $signed({1'b0, pct_mag[LANE_RIGHT]})
                                     : -$signed({1'b0, pct_mag[LANE_RIGHT]});
                for (int i = 0; i < 2; i++) begin
                    dneg_next[i]  = cur_src[i][7];
                    dprod_next[i] = {8'd0, cur_mag[i]};
                end
                cnt_next   = ddrpd_pkg::DUTY_MUL_LAST;
                state_next = ddrpd_pkg::ST_DUTY_MUL;
            end

            ddrpd_pkg::ST_RAMP:
            begin
                for (int i = 0; i < 2; i++) begin
                    cur_next[i]   = ramped[i];
                    dneg_next[i]  = cur_src[i][7];
                    dprod_next[i] = {8'd0, cur_mag[i]};
                end
                cnt_next   = ddrpd_pkg::DUTY_MUL_LAST;
                state_next = ddrpd_pkg::ST_DUTY_MUL;
            end

            ddrpd_pkg::ST_DUTY_MUL:
            begin
                for (int i = 0; i < 2; i++) begin
                    dprod_next[i] = dprod_reg[i][0] ? {duty_sum[i], dprod_reg[i][6:1]}
                                                   : {1'b0, dprod_reg[i][14:1]};
                end
                if (cnt_reg == '0) begin
                    state_next = ddrpd_pkg::ST_DUTY_OUT;
                end
                else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end

            ddrpd_pkg::ST_DUTY_OUT:
            begin
                // Wait here while the previous result still sits unclaimed.
                if (out_free) begin
                    duty_next.left_primary_duty    = dneg_reg[LANE_LEFT]
                                                   ? duty_offset_reg : drive_sat[LANE_LEFT];
                    duty_next.left_secondary_duty  = dneg_reg[LANE_LEFT]
                                                   ? drive_sat[LANE_LEFT] : duty_offset_reg;
                    duty_next.right_primary_duty   = dneg_reg[LANE_RIGHT]
                                                   ? duty_offset_reg : drive_sat[LANE_RIGHT];
                    duty_next.right_secondary_duty = dneg_reg[LANE_RIGHT]
                                                   ? drive_sat[LANE_RIGHT] : duty_offset_reg;
                    duty_valid_next = 1'b1;
                    state_next      = ddrpd_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ddrpd_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers and percents.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= ddrpd_pkg::ST_IDLE;
            cnt_reg        <= '0;
            cur_reg        <= '{default: '0};
            tgt_reg        <= '{default: '0};
            duty_valid_reg <= 1'b0;
        end
        else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            cur_reg        <= cur_next;
            tgt_reg        <= tgt_next;
            duty_valid_reg <= duty_valid_next;
        end
    end

    // Configuration registers; a write to an unknown index is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            accel_step_reg   <= ddrpd_pkg::ACCEL_STEP_RST;
            duty_offset_reg  <= ddrpd_pkg::DUTY_OFFSET_RST;
            period_scale_reg <= ddrpd_pkg::PERIOD_SCALE_RST;
            half_track_reg   <= ddrpd_pkg::HALF_TRACK_MM_RST;
            pct_scale_reg    <= ddrpd_pkg::PERCENT_PER_SPEED_RST;
        end
        else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                ddrpd_pkg::CFG_ACCEL_STEP:        accel_step_reg   <= cfg_data[7:0];
                ddrpd_pkg::CFG_DUTY_OFFSET:       duty_offset_reg  <= cfg_data;
                ddrpd_pkg::CFG_PERIOD_SCALE:      period_scale_reg <= cfg_data[7:0];
                ddrpd_pkg::CFG_HALF_TRACK_MM:     half_track_reg   <= cfg_data[10:0];
                ddrpd_pkg::CFG_PERCENT_PER_SPEED: pct_scale_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Payload shift registers need no reset.
    always_ff @(posedge clk)
    begin
        lin_reg     <= lin_next;
        ang_neg_reg <= ang_neg_next;
        mcand_reg   <= mcand_next;
        mix_reg     <= mix_next;
        rem_reg     <= rem_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        pprod_reg   <= pprod_next;
        dprod_reg   <= dprod_next;
        dneg_reg    <= dneg_next;
        duty_reg    <= duty_next;
    end

    // The left percents never leave the clamp range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (tgt_reg[LANE_LEFT] >= -8'sd100) && (tgt_reg[LANE_LEFT] <= 8'sd100) &&
        (cur_reg[LANE_LEFT] >= -8'sd100) && (cur_reg[LANE_LEFT] <= 8'sd100))
        else $error("left percent out of range");

    // The right percents never leave the clamp range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (tgt_reg[LANE_RIGHT] >= -8'sd100) && (tgt_reg[LANE_RIGHT] <= 8'sd100) &&
        (cur_reg[LANE_RIGHT] >= -8'sd100) && (cur_reg[LANE_RIGHT] <= 8'sd100))
        else $error("right percent out of range");

    // The sequencer starts work only on an accepted command beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ddrpd_pkg::ST_IDLE) && !cmd_valid |=> (state_reg == ddrpd_pkg::ST_IDLE))
        else $error("sequencer left idle without a command");

    // A finished result waits rather than overwrite one still unclaimed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ddrpd_pkg::ST_DUTY_OUT) && duty_valid_reg && !duty_ready
        |=> (state_reg == ddrpd_pkg::ST_DUTY_OUT) && duty_valid_reg)
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
